/* rtl/hte_pkg.sv */
// shared widths, payload structs and the divider step for the transfer error block
// no dependencies
`default_nettype none
package hte_pkg;

    localparam int CoordW   = 24;   // Q16.8 coordinates
    localparam int CoefW    = 32;   // homography coefficients
    localparam int ProdW    = CoordW + CoefW;
    localparam int AccW     = 60;   // signed u, v, w sums
    localparam int MagW     = 58;   // magnitudes of u, v, w
    localparam int DivShift = 28;   // dividend is |num| * 2^28
    localparam int QuotW    = 49;   // quotient bits kept after the range check
    localparam int FeedW    = QuotW - DivShift;   // numerator bits fed into the steps
    localparam int QrW      = QuotW + 1;          // rounded quotient
    localparam int DiffW    = 50;   // signed coordinate error
    localparam int SqInW    = 32;   // squaring operand
    localparam int SqW      = 2 * SqInW;
    localparam int ResW     = 48;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 64;
    localparam int InDataW  = 4 * CoordW;
    localparam int OutUserW = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegCoefPair0 = 8'd0;
    localparam logic [CfgIdxW-1:0] RegCoefPair1 = 8'd1;
    localparam logic [CfgIdxW-1:0] RegCoefPair2 = 8'd2;
    localparam logic [CfgIdxW-1:0] RegCoefPair3 = 8'd3;
    localparam logic [CfgIdxW-1:0] RegCoefLast  = 8'd4;

    localparam logic [CfgDataW-1:0] CoefPair0Rst = 64'h0000_0000_0100_0000;
    localparam logic [CfgDataW-1:0] CoefPair1Rst = 64'h0;
    localparam logic [CfgDataW-1:0] CoefPair2Rst = 64'h0000_0000_0100_0000;
    localparam logic [CfgDataW-1:0] CoefPair3Rst = 64'h0;
    localparam logic [CoefW-1:0]    CoefLastRst  = 32'h0100_0000;

    localparam logic [ResW-1:0] ResMax    = {ResW{1'b1}};
    localparam logic [QrW-1:0]  QuotPosLim = QrW'((64'd1 << 47) - 64'd1);
    localparam logic [QrW-1:0]  QuotNegLim = QrW'(64'd1 << 47);

    // item data that rides alongside the arithmetic
    typedef struct packed {
        logic signed [CoordW-1:0] dst_x;
        logic signed [CoordW-1:0] dst_y;
        logic                     zero;
        logic                     neg_u;
        logic                     neg_v;
    } t_side;

    typedef struct packed {
        t_side           side;
        logic [MagW-1:0] nu;
        logic [MagW-1:0] nv;
        logic [MagW-1:0] d;
    } t_mag;

    typedef struct packed {
        t_side            side;
        logic             ovf_u;
        logic             ovf_v;
        logic [QuotW-1:0] qu;
        logic [QuotW-1:0] qv;
        logic [MagW-1:0]  ru;
        logic [MagW-1:0]  rv;
        logic [MagW-1:0]  d;
    } t_quot;

    typedef struct packed {
        logic [ResW-1:0] residual;
        logic            degenerate;
        logic            saturated;
    } t_res;

    typedef struct packed {
        logic [MagW-1:0] rem;
        logic            qbit;
    } t_step;

    // one restoring division step: shift in a bit, subtract when it fits
    function automatic t_step div_step(input logic [MagW-1:0] rem, input logic bit_in,
                                       input logic [MagW-1:0] d);
        logic [MagW:0] t;
        t_step         s;
        t      = {rem, bit_in};
        s.qbit = (t >= {1'b0, d});
        s.rem  = s.qbit ? MagW'(t - {1'b0, d}) : MagW'(t);
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/homography_transfer_error.sv */
// Homography squared transfer error, top level.
// Input stream: one point correspondence per transaction on the s_axis group,
//   tdata = src_x, src_y, dst_x, dst_y from the lowest bit up, 24 bits each.
// Output stream: one result per input on the m_axis group, tdata = residual
//   (48 bits, unsigned Q32.16), tuser = degenerate (bit 0), saturated (bit 1).
// Configuration: cfg write channel, index 0..4 selects coef_pair_0..3 and
//   coef_last, other indexes are ignored; write only while the block is empty.
// Pipeline: 59 register stages (3 multiply-accumulate, the divider entry stage,
//   49 divider steps, 6 error stages); the result sits in the output register
//   of the last error stage and leaves from there, or from the skid register.
// Throughput: one item per cycle while the receiver keeps tready high.
// Stall: a skid register behind the pipeline catches the result that the
//   receiver refused; while it is full the whole pipeline holds and
//   s_axis_tready is low; nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and loads the
//   identity homography.
// depends on hte_pkg, hte_mac, hte_div, hte_err
`default_nettype none
module homography_transfer_error
    import hte_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [InDataW-1:0]    s_axis_tdata,   // src_x, src_y, dst_x, dst_y
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [ResW-1:0]      m_axis_tdata,   // residual
    output logic [OutUserW-1:0]  m_axis_tuser,   // degenerate, saturated
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CfgIdxW-1:0]    i_cfg_index,
    input  wire [CfgDataW-1:0]   i_cfg_data
);

    logic [CfgDataW-1:0] r_pair0, r_pair1, r_pair2, r_pair3;
    logic [CoefW-1:0]    r_last;
    logic                en;
    logic                mac_valid, div_valid, err_valid;
    t_mag                mac_mag;
    t_quot               div_quot;
    t_res                err_res;
    logic                r_skid_valid;
    t_res                r_skid;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair0 <= CoefPair0Rst;
            r_pair1 <= CoefPair1Rst;
            r_pair2 <= CoefPair2Rst;
            r_pair3 <= CoefPair3Rst;
            r_last  <= CoefLastRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegCoefPair0: r_pair0 <= i_cfg_data;
                RegCoefPair1: r_pair1 <= i_cfg_data;
                RegCoefPair2: r_pair2 <= i_cfg_data;
                RegCoefPair3: r_pair3 <= i_cfg_data;
                RegCoefLast:  r_last  <= i_cfg_data[CoefW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances while the skid register is empty
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    hte_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_src_x (s_axis_tdata[CoordW-1:0]),
        .i_src_y (s_axis_tdata[2*CoordW-1:CoordW]),
        .i_dst_x (s_axis_tdata[3*CoordW-1:2*CoordW]),
        .i_dst_y (s_axis_tdata[4*CoordW-1:3*CoordW]),
        .i_h00   (r_pair0[CoefW-1:0]),
        .i_h01   (r_pair0[2*CoefW-1:CoefW]),
        .i_h02   (r_pair1[CoefW-1:0]),
        .i_h10   (r_pair1[2*CoefW-1:CoefW]),
        .i_h11   (r_pair2[CoefW-1:0]),
        .i_h12   (r_pair2[2*CoefW-1:CoefW]),
        .i_h20   (r_pair3[CoefW-1:0]),
        .i_h21   (r_pair3[2*CoefW-1:CoefW]),
        .i_h22   (r_last),
        .o_valid (mac_valid),
        .o_mag   (mac_mag)
    );

    hte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mac_valid),
        .i_mag   (mac_mag),
        .o_valid (div_valid),
        .o_quot  (div_quot)
    );

    hte_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_quot  (div_quot),
        .o_valid (err_valid),
        .o_res   (err_res)
    );

    // skid register: catches the refused result as the pipeline shifts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (err_valid && !m_axis_tready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid <= err_res;
        end
    end

    // output mux
    assign m_axis_tvalid = r_skid_valid | err_valid;
    assign m_axis_tdata  = r_skid_valid ? r_skid.residual : err_res.residual;
    assign m_axis_tuser  = r_skid_valid ? {r_skid.saturated, r_skid.degenerate}
                                        : {err_res.saturated, err_res.degenerate};

endmodule
`default_nettype wire

/* rtl/hte_mac.sv */
// projective multiply-accumulate: u, v, w and their magnitudes, three stages
// depends on hte_pkg
`default_nettype none
module hte_mac
    import hte_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire signed [CoordW-1:0] i_src_x,
    input  wire signed [CoordW-1:0] i_src_y,
    input  wire signed [CoordW-1:0] i_dst_x,
    input  wire signed [CoordW-1:0] i_dst_y,
    input  wire signed [CoefW-1:0]  i_h00,
    input  wire signed [CoefW-1:0]  i_h01,
    input  wire signed [CoefW-1:0]  i_h02,
    input  wire signed [CoefW-1:0]  i_h10,
    input  wire signed [CoefW-1:0]  i_h11,
    input  wire signed [CoefW-1:0]  i_h12,
    input  wire signed [CoefW-1:0]  i_h20,
    input  wire signed [CoefW-1:0]  i_h21,
    input  wire signed [CoefW-1:0]  i_h22,
    output logic                    o_valid,
    output t_mag                    o_mag
);

    logic signed [ProdW-1:0]  r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    logic signed [CoefW-1:0]  r_h02, r_h12, r_h22;
    logic signed [CoordW-1:0] r_dx1, r_dy1, r_dx2, r_dy2;
    logic signed [AccW-1:0]   r_u, r_v, r_w;
    logic [2:0]               r_valid;
    t_mag                     r_mag;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= i_h00 * i_src_x;
            r_p01 <= i_h01 * i_src_y;
            r_p10 <= i_h10 * i_src_x;
            r_p11 <= i_h11 * i_src_y;
            r_p20 <= i_h20 * i_src_x;
            r_p21 <= i_h21 * i_src_y;
            r_h02 <= i_h02;
            r_h12 <= i_h12;
            r_h22 <= i_h22;
            r_dx1 <= i_dst_x;
            r_dy1 <= i_dst_y;
        end
    end

    // stage 2: sums, u and v with 32 fraction bits, w with 44
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u   <= AccW'(r_p00) + AccW'(r_p01) + (AccW'(r_h02) <<< 16);
            r_v   <= AccW'(r_p10) + AccW'(r_p11) + (AccW'(r_h12) <<< 16);
            r_w   <= AccW'(r_p20) + AccW'(r_p21) + (AccW'(r_h22) <<< 20);
            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
        end
    end

    // stage 3: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag.nu         <= MagW'(r_u[AccW-1] ? -r_u : r_u);
            r_mag.nv         <= MagW'(r_v[AccW-1] ? -r_v : r_v);
            r_mag.d          <= MagW'(r_w[AccW-1] ? -r_w : r_w);
            r_mag.side.dst_x <= r_dx2;
            r_mag.side.dst_y <= r_dy2;
            r_mag.side.zero  <= (r_w == '0);
            r_mag.side.neg_u <= r_u[AccW-1] ^ r_w[AccW-1];
            r_mag.side.neg_v <= r_v[AccW-1] ^ r_w[AccW-1];
        end
    end

    assign o_valid = r_valid[2];
    assign o_mag   = r_mag;

endmodule
`default_nettype wire

/* rtl/hte_div.sv */
// pipelined restoring divider for both coordinates, one quotient bit per stage
// depends on hte_pkg
`default_nettype none
module hte_div
    import hte_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  wire t_mag   i_mag,
    output logic        o_valid,
    output t_quot       o_quot
);

    logic [QuotW:0]   r_valid;
    logic [MagW-1:0]  r_rem_u [QuotW+1];
    logic [MagW-1:0]  r_rem_v [QuotW+1];
    logic [QuotW-1:0] r_feed_u [QuotW+1];
    logic [QuotW-1:0] r_feed_v [QuotW+1];
    logic [QuotW-1:0] r_q_u [QuotW+1];
    logic [QuotW-1:0] r_q_v [QuotW+1];
    logic [MagW-1:0]  r_d [QuotW+1];
    t_side            r_side [QuotW+1];
    logic             r_ovf_u [QuotW+1];
    logic             r_ovf_v [QuotW+1];
    t_step            n_su [QuotW];
    t_step            n_sv [QuotW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QuotW-1:0], i_valid};
        end
    end

    // entry: range check (quotient at or above 2^49 clips) and first partial remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf_u[0]  <= ((MagW+FeedW)'(i_mag.nu) >= {i_mag.d, FeedW'(0)});
            r_ovf_v[0]  <= ((MagW+FeedW)'(i_mag.nv) >= {i_mag.d, FeedW'(0)});
            r_rem_u[0]  <= i_mag.nu >> FeedW;
            r_rem_v[0]  <= i_mag.nv >> FeedW;
            r_feed_u[0] <= {i_mag.nu[FeedW-1:0], DivShift'(0)};
            r_feed_v[0] <= {i_mag.nv[FeedW-1:0], DivShift'(0)};
            r_q_u[0]    <= '0;
            r_q_v[0]    <= '0;
            r_d[0]      <= i_mag.d;
            r_side[0]   <= i_mag.side;
        end
    end

    // step logic of every stage
    always_comb begin
        for (int k = 0; k < QuotW; k++) begin
            n_su[k] = div_step(r_rem_u[k], r_feed_u[k][QuotW-1], r_d[k]);
            n_sv[k] = div_step(r_rem_v[k], r_feed_v[k][QuotW-1], r_d[k]);
        end
    end

    // step registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QuotW; k++) begin
                r_rem_u[k+1]  <= n_su[k].rem;
                r_rem_v[k+1]  <= n_sv[k].rem;
                r_feed_u[k+1] <= {r_feed_u[k][QuotW-2:0], 1'b0};
                r_feed_v[k+1] <= {r_feed_v[k][QuotW-2:0], 1'b0};
                r_q_u[k+1]    <= {r_q_u[k][QuotW-2:0], n_su[k].qbit};
                r_q_v[k+1]    <= {r_q_v[k][QuotW-2:0], n_sv[k].qbit};
                r_d[k+1]      <= r_d[k];
                r_side[k+1]   <= r_side[k];
                r_ovf_u[k+1]  <= r_ovf_u[k];
                r_ovf_v[k+1]  <= r_ovf_v[k];
            end
        end
    end

    assign o_valid      = r_valid[QuotW];
    assign o_quot.side  = r_side[QuotW];
    assign o_quot.ovf_u = r_ovf_u[QuotW];
    assign o_quot.ovf_v = r_ovf_v[QuotW];
    assign o_quot.qu    = r_q_u[QuotW];
    assign o_quot.qv    = r_q_v[QuotW];
    assign o_quot.ru    = r_rem_u[QuotW];
    assign o_quot.rv    = r_rem_v[QuotW];
    assign o_quot.d     = r_d[QuotW];

endmodule
`default_nettype wire

/* rtl/hte_err.sv */
// rounding, clipping, coordinate error, squares and final residual, six stages
// depends on hte_pkg
`default_nettype none
module hte_err
    import hte_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  wire t_quot  i_quot,
    output logic        o_valid,
    output t_res        o_res
);

    logic [5:0]              r_valid;
    t_side                   r_side1, r_side2, r_side3, r_side4, r_side5;
    logic                    r_ovf_u1, r_ovf_v1;
    logic [QrW-1:0]          r_qr_u, r_qr_v;
    logic signed [DiffW-1:0] r_qs_u, r_qs_v;
    logic                    r_clip2, r_clip3, r_clip4, r_clip5;
    logic signed [DiffW-1:0] r_ex, r_ey;
    logic [SqInW-1:0]        r_mx, r_my;
    logic                    r_big4, r_big5;
    logic [SqW-1:0]          r_sq_x, r_sq_y;
    t_res                    r_res;
    logic [QrW-1:0]          n_lim_u, n_lim_v, n_qm_u, n_qm_v;
    logic                    n_cl_u, n_cl_v;
    logic [DiffW-1:0]        n_ax, n_ay;
    logic [SqW:0]            n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    // stage 1: round to nearest, ties away from zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr_u   <= {1'b0, i_quot.qu} + QrW'({i_quot.ru, 1'b0} >= {1'b0, i_quot.d});
            r_qr_v   <= {1'b0, i_quot.qv} + QrW'({i_quot.rv, 1'b0} >= {1'b0, i_quot.d});
            r_ovf_u1 <= i_quot.ovf_u;
            r_ovf_v1 <= i_quot.ovf_v;
            r_side1  <= i_quot.side;
        end
    end

    // stage 2: clip to the signed Q32.16 range and apply the sign
    always_comb begin
        n_lim_u = r_side1.neg_u ? QuotNegLim : QuotPosLim;
        n_lim_v = r_side1.neg_v ? QuotNegLim : QuotPosLim;
        n_cl_u  = r_ovf_u1 || (r_qr_u > n_lim_u);
        n_cl_v  = r_ovf_v1 || (r_qr_v > n_lim_v);
        n_qm_u  = n_cl_u ? n_lim_u : r_qr_u;
        n_qm_v  = n_cl_v ? n_lim_v : r_qr_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qs_u  <= r_side1.neg_u ? -$signed(DiffW'(n_qm_u)) : $signed(DiffW'(n_qm_u));
            r_qs_v  <= r_side1.neg_v ? -$signed(DiffW'(n_qm_v)) : $signed(DiffW'(n_qm_v));
            r_clip2 <= n_cl_u | n_cl_v;
            r_side2 <= r_side1;
        end
    end

    // stage 3: coordinate errors with 16 fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex    <= (DiffW'(r_side2.dst_x) <<< 8) - r_qs_u;
            r_ey    <= (DiffW'(r_side2.dst_y) <<< 8) - r_qs_v;
            r_clip3 <= r_clip2;
            r_side3 <= r_side2;
        end
    end

    // stage 4: magnitudes and the too-large check
    always_comb begin
        n_ax = r_ex[DiffW-1] ? DiffW'(-r_ex) : DiffW'(r_ex);
        n_ay = r_ey[DiffW-1] ? DiffW'(-r_ey) : DiffW'(r_ey);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx    <= n_ax[SqInW-1:0];
            r_my    <= n_ay[SqInW-1:0];
            r_big4  <= (|n_ax[DiffW-1:SqInW]) | (|n_ay[DiffW-1:SqInW]);
            r_clip4 <= r_clip3;
            r_side4 <= r_side3;
        end
    end

    // stage 5: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x  <= r_mx * r_mx;
            r_sq_y  <= r_my * r_my;
            r_big5  <= r_big4;
            r_clip5 <= r_clip4;
            r_side5 <= r_side4;
        end
    end

    // stage 6: sum, round half up, saturate, degenerate override
    always_comb begin
        n_sum = (SqW+1)'(r_sq_x) + (SqW+1)'(r_sq_y) + (SqW+1)'(17'h08000);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_side5.zero) begin
                r_res.residual   <= ResMax;
                r_res.degenerate <= 1'b1;
                r_res.saturated  <= 1'b0;
            end else begin
                r_res.residual   <= (r_big5 || n_sum[SqW]) ? ResMax : n_sum[SqW-1:16];
                r_res.degenerate <= 1'b0;
                r_res.saturated  <= r_clip5 | r_big5 | n_sum[SqW];
            end
        end
    end

    assign o_valid = r_valid[5];
    assign o_res   = r_res;

endmodule
`default_nettype wire
